>>> design/cst_pkg.sv
`default_nettype none

package cst_pkg;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_START   = 3'd0,
    REQ_END     = 3'd1,
    REQ_ADVANCE = 3'd2,
    REQ_BACK    = 3'd3,
    REQ_ADD     = 3'd4,
    REQ_REMOVE  = 3'd5
  } cst_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_LOOK,
    ST_RESP
  } cst_state_t;

  // One request
  typedef struct packed {
    logic        [2:0]  req_type;
    logic signed [31:0] entry_value;
  } cst_req_t;

  // One response
  typedef struct packed {
    logic               op_error;
    logic               has_current;
    logic signed [31:0] current_value;
    logic        [5:0]  item_count;
    logic        [5:0]  cursor_pos;
  } cst_rsp_t;

endpackage

`default_nettype wire

>>> design/cursor_sequence_table.sv
`default_nettype none
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | cst_req_t (req_type, entry_value)
// rsp     | out       | rsp_valid / rsp_stall  | cst_rsp_t (error, cursor, value, count)
//
// Cursor moves and refused requests pass through accept, a memory read at the
// cursor and the response load. Add and remove first run one shift per entry
// moved, if any (add then writes the new value); each shift is a registered read followed
// by the write of that data one slot over.
// Reset (synchronous) empties the list and parks the cursor at 0; the memory
// is not cleared. A stalled response holds; the next request is taken meanwhile.

module cursor_sequence_table
  import cst_pkg::*;
#(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output      logic     req_stall,
  input  wire cst_req_t req,
  output      logic     rsp_valid,
  input  wire logic     rsp_stall,
  output      cst_rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  // sequencer: cursor, count, shift passes and response
  cst_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // list storage
  cst_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> design/cst_store.sv
`default_nettype none

module cst_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/cst_ctrl.sv
`default_nettype none

module cst_ctrl
  import cst_pkg::*;
#(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 5,
  parameter int CW          = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output      logic                   req_stall,
  input  wire cst_req_t               req,
  output      logic                   rsp_valid,
  input  wire logic                   rsp_stall,
  output      cst_rsp_t               rsp,
  output      logic                   mem_we,
  output      logic [AW-1:0]          mem_waddr,
  output      logic [VALUE_WIDTH-1:0] mem_wdata,
  output      logic                   mem_re,
  output      logic [AW-1:0]          mem_raddr,
  input  wire logic [VALUE_WIDTH-1:0] mem_rdata
);

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  cst_state_t state, state_next;

  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          cursor, cursor_next;
  logic [CW-1:0]          scan, scan_next;
  logic [CW-1:0]          slot, slot_next;
  logic                   shift_up, shift_up_next;
  logic                   err, err_next;
  logic [VALUE_WIDTH-1:0] val;

  logic                   accept;
  logic                   live;
  logic                   add_ok, add_shift, rem_ok, rem_shift;
  logic [CW-1:0]          add_slot;
  logic                   rsp_load;
  logic signed [VALUE_WIDTH-1:0] rd_s;

  assign accept = req_valid && !req_stall;
  assign live   = cursor < count;

  // add / remove preconditions and whether a shift pass is needed
  always_comb begin
    add_ok    = count < CAP;
    add_slot  = live ? (cursor + ONE) : '0;
    add_shift = count > add_slot;
    rem_ok    = live;
    rem_shift = (cursor + ONE) < count;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
          case (req.req_type)
            REQ_ADD: begin
              if (add_ok) begin
                state_next = add_shift ? ST_SHIFT_RD : ST_PUT;
              end
            end
            REQ_REMOVE: begin
              if (rem_ok && rem_shift) begin
                state_next = ST_SHIFT_RD;
              end
            end
            default: state_next = ST_LOOK;
          endcase
        end
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (shift_up) begin
          state_next = ((scan - ONE) > slot) ? ST_SHIFT_RD : ST_PUT;
        end else begin
          state_next = ((scan + ONE) < count) ? ST_SHIFT_RD : ST_LOOK;
        end
      end
      ST_PUT:  state_next = ST_LOOK;
      ST_LOOK: state_next = ST_RESP;
      ST_RESP: state_next = rsp_load ? ST_IDLE : ST_RESP;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: handshake and memory port control
  always_comb begin
    req_stall = (state != ST_IDLE);
    rsp_load  = (state == ST_RESP) && (!rsp_valid || !rsp_stall);
    mem_we    = 1'b0;
    mem_waddr = AW'(scan);
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = AW'(cursor);
    case (state)
      ST_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = shift_up ? AW'(scan - ONE) : AW'(scan);
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = shift_up ? AW'(scan) : AW'(scan - ONE);
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(slot);
        mem_wdata = val;
      end
      ST_LOOK: begin
        mem_re = 1'b1;
      end
      default: mem_re = 1'b0;
    endcase
  end

  // list bookkeeping: count, cursor and shift pointers
  always_comb begin
    count_next    = count;
    cursor_next   = cursor;
    scan_next     = scan;
    slot_next     = slot;
    shift_up_next = shift_up;
    err_next      = err;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          err_next = 1'b0;
          case (req.req_type)
            REQ_START: cursor_next = '0;
            REQ_END:   cursor_next = (count != '0) ? (count - ONE) : '0;
            REQ_ADVANCE: begin
              if (live) cursor_next = cursor + ONE;
              else      err_next    = 1'b1;
            end
            REQ_BACK: begin
              if (!live)               err_next    = 1'b1;
              else if (cursor == '0)   cursor_next = count;
              else                     cursor_next = cursor - ONE;
            end
            REQ_ADD: begin
              if (!add_ok) begin
                err_next = 1'b1;
              end else begin
                slot_next     = add_slot;
                scan_next     = count;
                shift_up_next = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (!rem_ok) begin
                err_next = 1'b1;
              end else begin
                scan_next     = cursor + ONE;
                shift_up_next = 1'b0;
                if (!rem_shift) count_next = count - ONE;
              end
            end
            default: err_next = 1'b1;
          endcase
        end
      end
      ST_SHIFT_WR: begin
        if (shift_up) begin
          scan_next = scan - ONE;
        end else begin
          scan_next = scan + ONE;
          if ((scan + ONE) >= count) count_next = count - ONE;
        end
      end
      ST_PUT: begin
        cursor_next = slot;
        count_next  = count + ONE;
      end
      default: err_next = err;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      cursor   <= '0;
      scan     <= '0;
      slot     <= '0;
      shift_up <= 1'b0;
      err      <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cursor   <= cursor_next;
      scan     <= scan_next;
      slot     <= slot_next;
      shift_up <= shift_up_next;
      err      <= err_next;
    end
  end

  // value to insert, held for the write
  always_ff @(posedge clk) begin
    if (accept) begin
      val <= VALUE_WIDTH'(req.entry_value);
    end
  end

  // response register; frees the request side while a response waits
  assign rd_s = mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.op_error      <= err;
      rsp.has_current   <= live;
      rsp.current_value <= live ? 32'(rd_s) : '0;
      rsp.item_count    <= 6'(count);
      rsp.cursor_pos    <= 6'(cursor);
    end
  end

endmodule

`default_nettype wire
